// ===== rtl/core/swmc_pkg.sv =====
package swmc_pkg;

    localparam int MAX_WINDOW_DEF = 1024;

    localparam int WINDOW_W = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int TYPE_W = 3;
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_LENGTH = 2'd0,
        CFG_COUNT_PRESENT = 2'd1,
        CFG_EMIT_PARTIAL  = 2'd2,
        CFG_ELEMENT_TYPE  = 2'd3
    } t_cfg_index;

    localparam logic [TYPE_W-1:0] TYPE_INT     = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_REAL    = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_STRING  = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_COMPLEX = 3'd4;

    localparam logic [31:0] INT_NA_PATTERN = 32'h8000_0000;

    typedef struct packed {
        logic flag;
        logic drop;
        logic last;
        logic raw;
        logic na;
        logic count_present;
    } t_ctrl;

    function automatic logic is_nan(input logic [VALUE_W-1:0] bits);
        is_nan = (&bits[62:52]) && (|bits[51:0]);
    endfunction

endpackage

// ===== rtl/core/sliding_window_missing_count_core.sv =====
// Counts missing (or, when selected, present) elements over a trailing window of a
// streamed vector and gives one result per element, one element per clock cycle in
// steady state unless the output stalls; the rate is set by the flag ring, which
// takes one read and one write per element. A result passes the front's stage
// register, the queue and the output register, and the two-entry queue between the
// classifying front and the counting back lets the input keep flowing while a
// result waits at the output. The window length is taken at the first element of
// each vector, and all counting state clears after the element marked last. The
// user must write configuration only while no element is in flight (not enforced).
module sliding_window_missing_count_core #(
    parameter int MAX_WINDOW = swmc_pkg::MAX_WINDOW_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [swmc_pkg::VALUE_W-1:0]     i_value_bits,
    input  logic [swmc_pkg::VALUE_W-1:0]     i_imag_bits,
    input  logic                             i_string_missing,
    input  logic                             i_last,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [swmc_pkg::COUNT_W-1:0]     o_window_count,
    output logic                             o_is_na,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [swmc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [swmc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int CTRL_W = $bits(swmc_pkg::t_ctrl);
    localparam int Q_W    = CTRL_W + 1 + WIN_W;

    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    swmc_pkg::t_ctrl   front_ctrl;
    logic              front_rd_flag;
    logic [WIN_W-1:0]  front_seen;
    logic [Q_W-1:0]    q_out;
    swmc_pkg::t_ctrl   back_ctrl;
    logic              back_rd_flag;
    logic [WIN_W-1:0]  back_seen;

    assign back_ctrl    = swmc_pkg::t_ctrl'(q_out[Q_W-1 -: CTRL_W]);
    assign back_rd_flag = q_out[WIN_W];
    assign back_seen    = q_out[WIN_W-1:0];

    swmc_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .WIN_W      (WIN_W)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_value_bits     (i_value_bits),
        .i_imag_bits      (i_imag_bits),
        .i_string_missing (i_string_missing),
        .i_last           (i_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_ctrl           (front_ctrl),
        .o_rd_flag        (front_rd_flag),
        .o_seen           (front_seen)
    );

    swmc_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({front_ctrl, front_rd_flag, front_seen}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    swmc_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .WIN_W      (WIN_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_ctrl         (back_ctrl),
        .i_rd_flag      (back_rd_flag),
        .i_seen         (back_seen),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_window_count (o_window_count),
        .o_is_na        (o_is_na)
    );

endmodule

// ===== rtl/core/swmc_front.sv =====
module swmc_front #(
    parameter int MAX_WINDOW = swmc_pkg::MAX_WINDOW_DEF,
    parameter int WIN_W      = $clog2(MAX_WINDOW + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [swmc_pkg::VALUE_W-1:0]        i_value_bits,
    input  logic [swmc_pkg::VALUE_W-1:0]        i_imag_bits,
    input  logic                                i_string_missing,
    input  logic                                i_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [swmc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [swmc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output swmc_pkg::t_ctrl                     o_ctrl,
    output logic                                o_rd_flag,
    output logic [WIN_W-1:0]                    o_seen
);

    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [swmc_pkg::WINDOW_W-1:0] r_cfg_window;
    logic                          r_cfg_present;
    logic                          r_cfg_partial;
    logic [swmc_pkg::TYPE_W-1:0]   r_cfg_type;

    logic [WIN_W-1:0]  r_seen;
    logic [WIN_W-1:0]  n_seen;
    logic [WIN_W-1:0]  r_win;
    logic [ADDR_W-1:0] r_wp;
    logic [ADDR_W-1:0] n_wp;

    logic              r_stage_valid;
    swmc_pkg::t_ctrl   r_stage_ctrl;
    logic [WIN_W-1:0]  r_stage_seen;
    logic              r_rd_flag;

    logic              r_ring [MAX_WINDOW];

    logic              accept;
    logic [WIN_W-1:0]  win_clamped;
    logic [WIN_W-1:0]  win_eff;
    logic [WIN_W-1:0]  wp_ext;
    logic [WIN_W-1:0]  seen_new;
    logic [ADDR_W-1:0] rd_addr;
    swmc_pkg::t_ctrl   ctrl;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_stage_valid && i_q_full;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_q_push    = r_stage_valid && !i_q_full;
    assign o_ctrl      = r_stage_ctrl;
    assign o_seen      = r_stage_seen;
    assign o_rd_flag   = r_rd_flag;

    always_comb begin
        if (r_cfg_window == '0) begin
            win_clamped = WIN_W'(1);
        end else if (32'(r_cfg_window) > 32'(MAX_WINDOW)) begin
            win_clamped = WIN_W'(MAX_WINDOW);
        end else begin
            win_clamped = WIN_W'(r_cfg_window);
        end
        win_eff = (r_seen == '0) ? win_clamped : r_win;

        ctrl.drop = r_seen >= win_eff;
        seen_new  = ctrl.drop ? r_seen : r_seen + WIN_W'(1);

        ctrl.raw  = 1'b0;
        case (r_cfg_type)
            swmc_pkg::TYPE_INT: begin
                ctrl.flag = i_value_bits[31:0] == swmc_pkg::INT_NA_PATTERN;
            end
            swmc_pkg::TYPE_REAL: begin
                ctrl.flag = swmc_pkg::is_nan(i_value_bits);
            end
            swmc_pkg::TYPE_STRING: begin
                ctrl.flag = i_string_missing;
            end
            swmc_pkg::TYPE_COMPLEX: begin
                ctrl.flag = swmc_pkg::is_nan(i_value_bits) || swmc_pkg::is_nan(i_imag_bits);
            end
            default: begin
                ctrl.flag = 1'b0;
                ctrl.raw  = 1'b1;
            end
        endcase

        ctrl.last          = i_last;
        ctrl.count_present = r_cfg_present;
        ctrl.na = !ctrl.raw && (seen_new < win_eff) && !i_last && !r_cfg_partial;

        wp_ext = WIN_W'(r_wp);
        if (wp_ext >= win_eff) begin
            rd_addr = ADDR_W'(wp_ext - win_eff);
        end else begin
            rd_addr = ADDR_W'(wp_ext + WIN_W'(MAX_WINDOW) - win_eff);
        end

        if (i_last) begin
            n_seen = '0;
            n_wp   = '0;
        end else begin
            n_seen = seen_new;
            n_wp   = (r_wp == ADDR_W'(MAX_WINDOW - 1)) ? '0 : r_wp + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_window <= swmc_pkg::WINDOW_W'(1);
            r_cfg_present <= 1'b0;
            r_cfg_partial <= 1'b0;
            r_cfg_type <= swmc_pkg::TYPE_INT;
        end else if (i_cfg_valid) begin
            case (swmc_pkg::t_cfg_index'(i_cfg_index))
                swmc_pkg::CFG_WINDOW_LENGTH: r_cfg_window <= i_cfg_data;
                swmc_pkg::CFG_COUNT_PRESENT: r_cfg_present <= i_cfg_data[0];
                swmc_pkg::CFG_EMIT_PARTIAL: r_cfg_partial <= i_cfg_data[0];
                swmc_pkg::CFG_ELEMENT_TYPE: r_cfg_type <= i_cfg_data[swmc_pkg::TYPE_W-1:0];
                default: r_cfg_window <= r_cfg_window;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_win <= WIN_W'(1);
            r_wp <= '0;
            r_stage_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_seen <= n_seen;
                r_win <= win_eff;
                r_wp <= n_wp;
                r_stage_valid <= 1'b1;
            end else if (o_q_push) begin
                r_stage_valid <= 1'b0;
            end
        end
    end

    // The ring is read before it is written, so a full-length window sees the old flag.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_wp] <= ctrl.flag;
            r_rd_flag <= r_ring[rd_addr];
            r_stage_ctrl <= ctrl;
            r_stage_seen <= seen_new;
        end
    end

endmodule

// ===== rtl/core/swmc_queue.sv =====
module swmc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/swmc_back.sv =====
module swmc_back #(
    parameter int MAX_WINDOW = swmc_pkg::MAX_WINDOW_DEF,
    parameter int WIN_W      = $clog2(MAX_WINDOW + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_empty,
    output logic                             o_q_pop,
    input  swmc_pkg::t_ctrl                  i_ctrl,
    input  logic                             i_rd_flag,
    input  logic [WIN_W-1:0]                 i_seen,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [swmc_pkg::COUNT_W-1:0]     o_window_count,
    output logic                             o_is_na
);

    logic [WIN_W-1:0]            r_total;
    logic [WIN_W-1:0]            total_new;
    logic [WIN_W-1:0]            count;
    logic                        r_out_valid;
    logic [swmc_pkg::COUNT_W-1:0] r_window_count;
    logic                        r_is_na;

    assign o_q_pop        = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid    = r_out_valid;
    assign o_window_count = r_window_count;
    assign o_is_na        = r_is_na;

    always_comb begin
        total_new = r_total - WIN_W'(i_ctrl.drop && i_rd_flag) + WIN_W'(i_ctrl.flag);
        if (i_ctrl.raw || i_ctrl.na) begin
            count = '0;
        end else if (i_ctrl.count_present) begin
            count = i_seen - total_new;
        end else begin
            count = total_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_total <= i_ctrl.last ? '0 : total_new;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_window_count <= swmc_pkg::COUNT_W'(count);
            r_is_na <= i_ctrl.na;
        end
    end

endmodule
